@@ design/u2d_pkg.sv @@
// ----------------------------------------------------------------------------
// u2d_pkg: shared types and constants for the decimal ASCII converter
// Widths of the binary value, the BCD word and the digit stream, plus the
// double-dabble shift step used by the converter.
// ----------------------------------------------------------------------------
package u2d_pkg;

	localparam int VALUE_W       = 64;
	localparam int DIGITS        = 20;
	localparam int BCD_W         = 4 * DIGITS;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = VALUE_W / BITS_PER_STEP;
	localparam int STEP_CNT_W    = $clog2(STEPS);
	localparam int DIGIT_IDX_W   = $clog2(DIGITS);
	localparam int CHAR_W        = 6;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef logic [BCD_W-1:0] bcd_t;

	// one double-dabble step: adjust every digit >= 5, then shift in one bit
	function automatic bcd_t dd_shift(bcd_t b, logic din);
		bcd_t adj;
		adj = b;
		for (int d = 0; d < DIGITS; d++) begin
			if (b[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = b[4*d +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], din};
	endfunction

endpackage

@@ design/u2d_front.sv @@
// ----------------------------------------------------------------------------
// u2d_front: binary to BCD converter
// Takes one 64-bit value, converts it four bits per cycle by shift-and-add-3,
// then hands the 20-digit BCD word to the queue.
// ----------------------------------------------------------------------------
module u2d_front
	import u2d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_valid,
	output logic               value_ready,
	input  logic [VALUE_W-1:0] value,
	output logic               push_valid,
	input  logic               push_ready,
	output bcd_t               push_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_PUSH = 3'b100
	} state_t;

	state_t                  state_q;
	logic [STEP_CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0]      bin_q;
	bcd_t                    bcd_q;
	bcd_t                    bcd_nxt;

	always_comb begin
		bcd_nxt = bcd_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			bcd_nxt = dd_shift(bcd_nxt, bin_q[VALUE_W-1-i]);
		end
	end

	assign value_ready = (state_q == ST_IDLE);
	assign push_valid  = (state_q == ST_PUSH);
	assign push_data   = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (value_valid) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_CNT_W'(STEPS - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && value_valid) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[VALUE_W-1-BITS_PER_STEP:0], {BITS_PER_STEP{1'b0}}};
			bcd_q <= bcd_nxt;
		end
	end

endmodule

@@ design/u2d_queue.sv @@
// ----------------------------------------------------------------------------
// u2d_queue: small register queue
// Decouples the converter from the character serializer.
// ----------------------------------------------------------------------------
module u2d_queue #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ design/u2d_back.sv @@
// ----------------------------------------------------------------------------
// u2d_back: character serializer
// Pops one BCD word and emits its 20 digits as ASCII, most significant
// first, through an output register; last marks the final digit.
// ----------------------------------------------------------------------------
module u2d_back
	import u2d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  bcd_t              pop_data,
	output logic              character_valid,
	input  logic              character_ready,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	localparam logic [DIGIT_IDX_W-1:0] LAST_IDX = DIGIT_IDX_W'(DIGITS - 1);

	bcd_t                   word_q;
	logic                   have_q;
	logic [DIGIT_IDX_W-1:0] idx_q;
	logic                   valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   load_en;
	logic                   emit;
	logic                   fin;
	logic                   do_pop;

	assign load_en   = !valid_q || character_ready;
	assign emit      = load_en && have_q;
	assign fin       = emit && (idx_q == LAST_IDX);
	assign pop_ready = !have_q || fin;
	assign do_pop    = pop_valid && pop_ready;

	assign character_valid = valid_q;
	assign character       = char_q;
	assign last            = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load_en) begin
				valid_q <= have_q;
			end
			if (do_pop) begin
				have_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
				if (fin) begin
					have_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, word_q[BCD_W-1 -: 4]};
			last_q <= (idx_q == LAST_IDX);
		end
		if (do_pop) begin
			word_q <= pop_data;
		end else if (emit) begin
			word_q <= {word_q[BCD_W-5:0], 4'b0000};
		end
	end

endmodule

@@ design/u64_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// u64_to_decimal_ascii: unsigned 64-bit value to 20-character decimal text
//
// Input channel value_valid/value_ready carries one 64-bit value per item.
// Output channel character_valid/character_ready carries one ASCII digit per
// item, most significant first, zero padded, 20 per value; last is set on
// the twentieth digit.
// The first digit of a value passes through 16 shift-and-add-3 steps of
// four bits, the hand-over of the BCD word to the queue, the load of the
// serializer and one output register.
// The output carries one character per cycle while character_ready is high.
// The converter takes a new value only once its last BCD word is pushed;
// the queue of QUEUE_DEPTH BCD words lets it run ahead of the serializer.
// When the receiver stalls, the output register holds its character, the
// serializer stops and the queue fills; value_ready, low whenever the
// converter is busy, then stays low until the queue has room.
// Reset clears all control state; no characters are pending afterwards.
// ----------------------------------------------------------------------------
module u64_to_decimal_ascii
	import u2d_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_valid,
	output logic               value_ready,
	input  logic [VALUE_W-1:0] value,
	output logic               character_valid,
	input  logic               character_ready,
	output logic [CHAR_W-1:0]  character,
	output logic               last
);

	logic q_push_valid;
	logic q_push_ready;
	bcd_t q_push_data;
	logic q_pop_valid;
	logic q_pop_ready;
	bcd_t q_pop_data;

	u2d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value       (value),
		.push_valid  (q_push_valid),
		.push_ready  (q_push_ready),
		.push_data   (q_push_data)
	);

	u2d_queue #(
		.WIDTH (BCD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	u2d_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (q_pop_valid),
		.pop_ready       (q_pop_ready),
		.pop_data        (q_pop_data),
		.character_valid (character_valid),
		.character_ready (character_ready),
		.character       (character),
		.last            (last)
	);

`ifndef ASSERT_OFF
	a_char_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		character_valid |-> (character >= ASCII_ZERO) && (character <= ASCII_ZERO + 6'd9))
		else $error("character outside '0'..'9'");

	a_one_pop_per_word: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop_valid && q_pop_ready) |=> !q_pop_ready)
		else $error("serializer popped a second word before finishing");

	a_full_queue_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!q_push_ready |-> q_pop_valid)
		else $error("queue reports full while empty");
`endif

endmodule
